[design/mpae_pkg.sv]
// Shared types, codes and defaults for the max pooling engine.
package mpae_pkg;

  localparam int INPUT_DEPTH  = 4096;
  localparam int OUTPUT_DEPTH = 1024;
  localparam int MAX_KERNEL   = 8;

  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_POOL     = 2'd1;
  localparam logic [1:0] OP_BACKWARD = 2'd2;
  localparam logic [1:0] OP_READ     = 2'd3;

  localparam logic [2:0] REG_IN_HEIGHT     = 3'd0;
  localparam logic [2:0] REG_IN_WIDTH      = 3'd1;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [2:0] REG_OUT_HEIGHT    = 3'd3;
  localparam logic [2:0] REG_OUT_WIDTH     = 3'd4;
  localparam logic [2:0] REG_KERNEL_H      = 3'd5;
  localparam logic [2:0] REG_KERNEL_W      = 3'd6;
  localparam logic [2:0] REG_STRIDE        = 3'd7;

  typedef struct packed {
    logic [1:0]         operation;
    logic [11:0]        elem_index;
    logic signed [31:0] sample_value;
    logic [3:0]         batch_index;
    logic [5:0]         out_row;
    logic [5:0]         out_col;
    logic [5:0]         channel;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic [6:0] in_height;
    logic [6:0] in_width;
    logic [6:0] channel_count;
    logic [6:0] out_height;
    logic [6:0] out_width;
    logic [3:0] kernel_h;
    logic [3:0] kernel_w;
    logic [3:0] stride;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    in_height: 7'd1, in_width: 7'd1, channel_count: 7'd1,
    out_height: 7'd1, out_width: 7'd1,
    kernel_h: 4'd2, kernel_w: 4'd2, stride: 4'd2
  };

endpackage

[design/mpae_if.sv]
// Channel interfaces: request, response and register write.
interface mpae_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [11:0]        elem_index;
  logic signed [31:0] sample_value;
  logic [3:0]         batch_index;
  logic [5:0]         out_row;
  logic [5:0]         out_col;
  logic [5:0]         channel;
  modport source (output valid, operation, elem_index, sample_value, batch_index,
                  out_row, out_col, channel, input ready);
  modport sink (input valid, operation, elem_index, sample_value, batch_index,
                out_row, out_col, channel, output ready);
endinterface

interface mpae_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [11:0]        source_index;
  logic               is_gradient;
  modport source (output valid, result_value, source_index, is_gradient, input ready);
  modport sink (input valid, result_value, source_index, is_gradient, output ready);
endinterface

interface mpae_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/mpae_front.sv]
// Front end: takes request transactions into a two-entry queue.
module mpae_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           clearing,
  mpae_req_if.sink       req,
  output mpae_pkg::head_t head,
  input  logic           pop
);

  mpae_pkg::item_t slots [2];
  mpae_pkg::item_t incoming;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;

  assign req.ready = (count != 2'd2) && !clearing;
  assign push      = req.valid && req.ready;

  always_comb begin
    incoming.operation    = req.operation;
    incoming.elem_index   = req.elem_index;
    incoming.sample_value = req.sample_value;
    incoming.batch_index  = req.batch_index;
    incoming.out_row      = req.out_row;
    incoming.out_col      = req.out_col;
    incoming.channel      = req.channel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= incoming;
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];

endmodule

[design/mpae_back.sv]
// Back end: sequencer, stores, window scan and response register.
module mpae_back #(
  parameter int INPUT_DEPTH  = mpae_pkg::INPUT_DEPTH,
  parameter int OUTPUT_DEPTH = mpae_pkg::OUTPUT_DEPTH,
  parameter int MAX_KERNEL   = mpae_pkg::MAX_KERNEL
) (
  input  logic            clk,
  input  logic            rst,
  input  mpae_pkg::cfg_t  cfg,
  input  mpae_pkg::head_t head,
  output logic            pop,
  output logic            clearing,
  mpae_rsp_if.source      rsp
);

  localparam int IAW = $clog2(INPUT_DEPTH);
  localparam int OAW = $clog2(OUTPUT_DEPTH);
  localparam int KCW = $clog2(MAX_KERNEL + 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SETUP1 = 4'd2;
  localparam logic [3:0] S_SETUP2 = 4'd3;
  localparam logic [3:0] S_SETUP3 = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_DRAIN  = 4'd6;
  localparam logic [3:0] S_FINISH = 4'd7;
  localparam logic [3:0] S_GRAD   = 4'd8;
  localparam logic [3:0] S_BK1    = 4'd9;
  localparam logic [3:0] S_BK2    = 4'd10;
  localparam logic [3:0] S_BK3    = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;

  logic [3:0]      state;
  mpae_pkg::item_t cur;
  logic [IAW-1:0]  clr_cnt;

  logic [IAW-1:0]  t1, t2, base_next, wc, row_addr, cur_addr;
  logic [OAW-1:0]  o1, o2, o3;
  logic [9:0]      rs, cs;
  logic [KCW-1:0]  i, j, kh, kw;
  logic [4:0]      kh5, kw5;
  logic [10:0]     ph, pw;
  logic            in_window, last_j, last_i;

  logic               rd_v;
  logic [IAW-1:0]     rd_pos;
  logic               found;
  logic signed [31:0] best;
  logic [IAW-1:0]     best_pos;
  logic [IAW+11:0]    best_ext;

  logic signed [31:0] hold_val;
  logic [11:0]        hold_idx;
  logic               hold_grad;
  logic [IAW-1:0]     tgt;

  logic [IAW+11:0]    head_ext, cur_ext;
  logic [IAW-1:0]     head_elem, cur_elem;

  logic signed [31:0] in_mem [INPUT_DEPTH];
  logic signed [31:0] in_q;
  logic [IAW-1:0]     am_mem [OUTPUT_DEPTH];
  logic [IAW-1:0]     am_q;
  logic signed [31:0] gr_mem [INPUT_DEPTH];
  logic signed [31:0] gr_q;

  logic               gr_we;
  logic [IAW-1:0]     gr_waddr, gr_raddr;
  logic signed [31:0] gr_wdata;
  logic signed [32:0] sum;
  logic signed [31:0] sat;
  logic               load;

  // kernel saturates at MAX_KERNEL
  assign kh5 = ({1'b0, cfg.kernel_h} > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) : {1'b0, cfg.kernel_h};
  assign kw5 = ({1'b0, cfg.kernel_w} > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) : {1'b0, cfg.kernel_w};
  assign kh  = KCW'(kh5);
  assign kw  = KCW'(kw5);

  assign head_ext  = (IAW + 12)'(head.item.elem_index);
  assign cur_ext   = (IAW + 12)'(cur.elem_index);
  assign head_elem = head_ext[IAW-1:0];
  assign cur_elem  = cur_ext[IAW-1:0];
  assign best_ext  = (IAW + 12)'(best_pos);

  assign ph        = {1'b0, rs} + 11'(i);
  assign pw        = {1'b0, cs} + 11'(j);
  assign in_window = (ph < 11'(cfg.in_height)) && (pw < 11'(cfg.in_width));
  assign last_j    = (j == kw - 1'b1);
  assign last_i    = (i == kh - 1'b1);

  assign base_next = t2 * IAW'(cfg.channel_count) + IAW'(cur.channel);

  assign pop      = (state == S_IDLE) && head.valid;
  assign clearing = (state == S_CLEAR);
  assign load     = (state == S_EMIT) && (!rsp.valid || rsp.ready);

  // saturating gradient add
  assign sum = {gr_q[31], gr_q} + {cur.sample_value[31], cur.sample_value};
  always_comb begin
    sat = sum[31:0];
    if (sum[32] != sum[31]) sat = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  end

  always_comb begin
    gr_we    = 1'b0;
    gr_waddr = cur_elem;
    gr_wdata = '0;
    case (state)
      S_CLEAR: begin
        gr_we    = 1'b1;
        gr_waddr = clr_cnt;
      end
      S_GRAD: gr_we = 1'b1;
      S_BK3: begin
        gr_we    = 1'b1;
        gr_waddr = tgt;
        gr_wdata = sat;
      end
      default: gr_we = 1'b0;
    endcase
  end

  assign gr_raddr = (state == S_IDLE) ? head_elem : am_q;

  always_ff @(posedge clk) begin
    if (gr_we) gr_mem[gr_waddr] <= gr_wdata;
    gr_q <= gr_mem[gr_raddr];
  end

  always_ff @(posedge clk) begin
    if (pop && head.item.operation == mpae_pkg::OP_WRITE)
      in_mem[head_elem] <= head.item.sample_value;
    in_q <= in_mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH) am_mem[o3] <= best_pos;
    am_q <= am_mem[o3];
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) state <= S_IDLE;
        end
        S_IDLE: begin
          if (head.valid) begin
            case (head.item.operation)
              mpae_pkg::OP_WRITE: state <= S_IDLE;
              mpae_pkg::OP_READ:  state <= S_GRAD;
              default:            state <= S_SETUP1;
            endcase
          end
        end
        S_SETUP1: state <= S_SETUP2;
        S_SETUP2: state <= S_SETUP3;
        S_SETUP3: begin
          if (cur.operation == mpae_pkg::OP_POOL)
            state <= (kh == '0 || kw == '0) ? S_DRAIN : S_SCAN;
          else
            state <= S_BK1;
        end
        S_SCAN:   if (last_j && last_i) state <= S_DRAIN;
        S_DRAIN:  state <= S_FINISH;
        S_FINISH: state <= S_EMIT;
        S_GRAD:   state <= S_EMIT;
        S_BK1:    state <= S_BK2;
        S_BK2:    state <= S_BK3;
        S_BK3:    state <= S_IDLE;
        S_EMIT:   if (load) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // datapath: address setup, scan counters, running max
  always_ff @(posedge clk) begin
    if (pop) cur <= head.item;
    case (state)
      S_SETUP1: begin
        t1 <= IAW'(cur.batch_index) * IAW'(cfg.in_height);
        rs <= 10'(cur.out_row) * 10'(cfg.stride);
        cs <= 10'(cur.out_col) * 10'(cfg.stride);
        o1 <= OAW'(cur.batch_index) * OAW'(cfg.out_height) + OAW'(cur.out_row);
      end
      S_SETUP2: begin
        t2 <= (t1 + IAW'(rs)) * IAW'(cfg.in_width) + IAW'(cs);
        o2 <= o1 * OAW'(cfg.out_width) + OAW'(cur.out_col);
      end
      S_SETUP3: begin
        wc       <= IAW'(cfg.in_width) * IAW'(cfg.channel_count);
        o3       <= o2 * OAW'(cfg.channel_count) + OAW'(cur.channel);
        row_addr <= base_next;
        cur_addr <= base_next;
        i        <= '0;
        j        <= '0;
      end
      S_SCAN: begin
        if (last_j) begin
          j        <= '0;
          i        <= i + 1'b1;
          row_addr <= row_addr + wc;
          cur_addr <= row_addr + wc;
        end else begin
          j        <= j + 1'b1;
          cur_addr <= cur_addr + IAW'(cfg.channel_count);
        end
      end
      S_FINISH: begin
        hold_val  <= best;
        hold_idx  <= best_ext[11:0];
        hold_grad <= 1'b0;
      end
      S_GRAD: begin
        hold_val  <= gr_q;
        hold_idx  <= cur.elem_index;
        hold_grad <= 1'b1;
      end
      S_BK2:   tgt <= am_q;
      default: tgt <= tgt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= (state == S_SCAN) && in_window;
    end
    rd_pos <= cur_addr;
    if (state == S_SETUP3) begin
      found    <= 1'b0;
      best     <= 32'sh8000_0000;
      best_pos <= '0;
    end else if (rd_v && (!found || in_q > best)) begin
      found    <= 1'b1;
      best     <= in_q;
      best_pos <= rd_pos;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.result_value <= hold_val;
      rsp.source_index <= hold_idx;
      rsp.is_gradient  <= hold_grad;
    end
  end

endmodule

[design/max_pool_argmax_engine_top.sv]
// Top level of the max pooling engine with argmax and gradient store.
// Operations: write stores a sample; read and clear loads the gradient into the response
// register; backward adds into the gradient store; pool scans the kh*kw window at one
// input store read per cycle, then loads the response register.
// Throughput: one transaction at a time in the back end; a two-entry queue takes more.
// Reset: synchronous; config returns to defaults and the gradient store's INPUT_DEPTH
// entries (4096 by default) are cleared, during which no request transaction is accepted.
module max_pool_argmax_engine_top #(
  parameter int INPUT_DEPTH  = mpae_pkg::INPUT_DEPTH,
  parameter int OUTPUT_DEPTH = mpae_pkg::OUTPUT_DEPTH,
  parameter int MAX_KERNEL   = mpae_pkg::MAX_KERNEL
) (
  input logic        clk,
  input logic        rst,
  mpae_req_if.sink   req,
  mpae_rsp_if.source rsp,
  mpae_cfg_if.sink   cfg
);

  mpae_pkg::cfg_t  cfg_regs;
  mpae_pkg::head_t head;
  logic            pop;
  logic            clearing;

  // register writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= mpae_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        mpae_pkg::REG_IN_HEIGHT:     cfg_regs.in_height     <= cfg.data;
        mpae_pkg::REG_IN_WIDTH:      cfg_regs.in_width      <= cfg.data;
        mpae_pkg::REG_CHANNEL_COUNT: cfg_regs.channel_count <= cfg.data;
        mpae_pkg::REG_OUT_HEIGHT:    cfg_regs.out_height    <= cfg.data;
        mpae_pkg::REG_OUT_WIDTH:     cfg_regs.out_width     <= cfg.data;
        mpae_pkg::REG_KERNEL_H:      cfg_regs.kernel_h      <= cfg.data[3:0];
        mpae_pkg::REG_KERNEL_W:      cfg_regs.kernel_w      <= cfg.data[3:0];
        mpae_pkg::REG_STRIDE:        cfg_regs.stride        <= cfg.data[3:0];
        default:                     cfg_regs               <= cfg_regs;
      endcase
    end
  end

  // front: request queue
  mpae_front u_front (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .req      (req),
    .head     (head),
    .pop      (pop)
  );

  // back: sequencer, stores and response register
  mpae_back #(
    .INPUT_DEPTH  (INPUT_DEPTH),
    .OUTPUT_DEPTH (OUTPUT_DEPTH),
    .MAX_KERNEL   (MAX_KERNEL)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_regs),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

endmodule

[design/mpae_checker.sv]
// Port-level checks for the max pooling engine, bound to the top level.
module mpae_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] result_value,
  input logic [11:0] source_index,
  input logic        is_gradient
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_value) &&
      $stable(source_index) && $stable(is_gradient))
    else $error("response changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("request taken or response shown right after reset");

  a_clear_blocks: assert property (@(posedge clk)
    !rst && $past(rst) |=> !req_ready)
    else $error("request taken during gradient clear");

endmodule

bind max_pool_argmax_engine_top mpae_checker u_mpae_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .result_value (rsp.result_value),
  .source_index (rsp.source_index),
  .is_gradient  (rsp.is_gradient)
);
